// File: hw/rtl/lcbc_pkg.sv
package lcbc_pkg;

   localparam int CARD_W         = 63;
   localparam int REQ_DATA_W     = 64;
   localparam int RSP_DATA_W     = 8;
   localparam int MAX_DIGITS_DEF = 19;
   localparam int BCD_DIGITS     = 19;
   localparam int BCD_W          = 4 * BCD_DIGITS;
   localparam int COUNT_W        = 5;
   localparam int BITS_PER_STEP  = 7;
   localparam int CONV_STEPS     = CARD_W / BITS_PER_STEP;
   localparam int CONV_CNT_W     = 4;
   localparam int UPC_W          = 2;

   typedef logic [3:0] digit_type;

   // issuer rules
   localparam logic [COUNT_W-1:0] VISA_LEN_MIN  = 5'd13;
   localparam logic [COUNT_W-1:0] VISA_LEN_MAX  = 5'd16;
   localparam logic [COUNT_W-1:0] MC_LEN        = 5'd16;
   localparam logic [COUNT_W-1:0] AMEX_LEN      = 5'd15;
   localparam digit_type          VISA_LEAD     = 4'd4;
   localparam digit_type          MC_LEAD       = 4'd5;
   localparam digit_type          MC_SECOND_LO  = 4'd1;
   localparam digit_type          MC_SECOND_HI  = 4'd5;
   localparam digit_type          AMEX_LEAD     = 4'd3;
   localparam digit_type          AMEX_SECOND_A = 4'd4;
   localparam digit_type          AMEX_SECOND_B = 4'd7;

   typedef enum logic [1:0] {
      BRAND_INVALID    = 2'd0,
      BRAND_VISA       = 2'd1,
      BRAND_MASTERCARD = 2'd2,
      BRAND_AMEX       = 2'd3
   } brand_type;

   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_CONVERT  = 2'd1,
      OP_DIGIT    = 2'd2,
      OP_CLASSIFY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      COND_NO_REQ     = 2'd0,
      COND_CONV_MORE  = 2'd1,
      COND_DIGIT_MORE = 2'd2,
      COND_OUT_BUSY   = 2'd3
   } cond_type;

   typedef enum logic [1:0] {
      EXEC_ALWAYS   = 2'd0,
      EXEC_IF_TRUE  = 2'd1,
      EXEC_IF_FALSE = 2'd2
   } exec_type;

   typedef logic [UPC_W-1:0] upc_type;

   localparam upc_type STEP_IDLE     = 2'd0;
   localparam upc_type STEP_CONVERT  = 2'd1;
   localparam upc_type STEP_DIGIT    = 2'd2;
   localparam upc_type STEP_CLASSIFY = 2'd3;

   typedef struct packed {
      op_type   op;
      exec_type exec;
      cond_type cond;
      upc_type  target;
   } ctrl_word_type;

   typedef struct packed {
      op_type op;
      logic   en;
   } dp_ctrl_type;

   typedef struct packed {
      logic conv_more;
      logic digit_more;
      logic out_busy;
   } dp_status_type;

endpackage

// File: hw/rtl/luhn_card_brand_check.sv
// Luhn mod-10 check of a card number with issuer classification.
// req channel: one word per card number, the number in req_tdata[62:0];
//   req_tready is high only while the block waits for a new number.
// rsp channel: one word per number: brand, luhn_ok and digit_count.
// Control is a four-step microprogram: load, convert, digit walk, classify.
// Sequence from the accept edge: binary-to-BCD conversion at 7 bits per
//   cycle, then the digit walk for a number of n digits (one digit per
//   cycle through the checksum adder), then the classify step, after
//   which rsp_tvalid rises.
// The next number is taken in the cycle after classify, so the block
//   works on one number at a time.
// The result sits in an output register; if the receiver stalls, the block
//   still takes and works on the next number and holds in its classify step
//   until the pending word is taken.
// Reset (synchronous) returns the sequencer to idle and drops rsp_tvalid.
module luhn_card_brand_check
   import lcbc_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [62:0] card_number, [63] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // [1:0] brand, [2] luhn_ok, [7:3] digit_count
);

   dp_ctrl_type        ctrl;
   dp_status_type      status;
   brand_type          brand;
   logic               luhn_ok;
   logic [COUNT_W-1:0] digit_count;

   lcbc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .ctrl       (ctrl),
      .idle       (req_tready)
   );

   lcbc_dpath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .card_number (req_tdata[CARD_W-1:0]),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .rsp_valid   (rsp_tvalid),
      .brand       (brand),
      .luhn_ok     (luhn_ok),
      .digit_count (digit_count)
   );

   assign rsp_tdata = {digit_count, luhn_ok, brand};

endmodule

// File: hw/rtl/lcbc_seq.sv
module lcbc_seq
   import lcbc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  dp_status_type status,
   output dp_ctrl_type   ctrl,
   output logic          idle
);

   // one control word per step; a true condition jumps to target, else fall through
   localparam ctrl_word_type UCODE [4] = '{
      '{op: OP_LOAD,     exec: EXEC_IF_FALSE, cond: COND_NO_REQ,     target: STEP_IDLE},
      '{op: OP_CONVERT,  exec: EXEC_ALWAYS,   cond: COND_CONV_MORE,  target: STEP_CONVERT},
      '{op: OP_DIGIT,    exec: EXEC_IF_TRUE,  cond: COND_DIGIT_MORE, target: STEP_DIGIT},
      '{op: OP_CLASSIFY, exec: EXEC_IF_FALSE, cond: COND_OUT_BUSY,   target: STEP_CLASSIFY}
   };

   upc_type       upc_ff;
   upc_type       upc_in;
   ctrl_word_type cw;
   logic          cond_true;

   assign cw = UCODE[upc_ff];

   always_comb begin
      case (cw.cond)
         COND_NO_REQ:     cond_true = !req_tvalid;
         COND_CONV_MORE:  cond_true = status.conv_more;
         COND_DIGIT_MORE: cond_true = status.digit_more;
         COND_OUT_BUSY:   cond_true = status.out_busy;
         default:         cond_true = 1'b0;
      endcase
   end

   always_comb begin
      ctrl.op = cw.op;
      case (cw.exec)
         EXEC_ALWAYS:   ctrl.en = 1'b1;
         EXEC_IF_TRUE:  ctrl.en = cond_true;
         EXEC_IF_FALSE: ctrl.en = !cond_true;
         default:       ctrl.en = 1'b0;
      endcase
   end

   // last step wraps back to idle
   assign upc_in = cond_true ? cw.target : upc_type'(upc_ff + 1'b1);
   // hold off new words while in reset
   assign idle   = (upc_ff == STEP_IDLE) && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// File: hw/rtl/lcbc_dpath.sv
module lcbc_dpath
   import lcbc_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  dp_ctrl_type        ctrl,
   input  logic [CARD_W-1:0]  card_number,
   input  logic               rsp_tready,
   output dp_status_type      status,
   output logic               rsp_valid,
   output brand_type          brand,
   output logic               luhn_ok,
   output logic [COUNT_W-1:0] digit_count
);

   logic [CARD_W-1:0]     bin_ff;
   logic [BCD_W-1:0]      bcd_ff;
   logic [CONV_CNT_W-1:0] conv_cnt_ff;
   logic [COUNT_W-1:0]    count_ff;
   digit_type             sum_ff;
   digit_type             lead_ff;
   digit_type             second_ff;
   logic                  rsp_valid_ff;
   brand_type             brand_ff;
   logic                  ok_ff;
   logic [COUNT_W-1:0]    dcount_ff;

   logic [CARD_W-1:0]     bin_in;
   logic [BCD_W-1:0]      bcd_in;
   digit_type             sum_in;
   digit_type             cur_digit;
   logic [4:0]            doubled;
   digit_type             addend;
   logic [4:0]            sum_raw;
   logic                  overflow;
   logic                  ok_in;
   brand_type             brand_in;

   // double-dabble: several bits per cycle, each bit an add-3 pass then a shift
   always_comb begin
      digit_type dg;
      dg     = '0;
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int k = 0; k < BCD_DIGITS; k++) begin
            dg = bcd_in[4*k +: 4];
            if (dg >= 4'd5) begin
               bcd_in[4*k +: 4] = dg + 4'd3;
            end
         end
         bcd_in = {bcd_in[BCD_W-2:0], bin_in[CARD_W-1]};
         bin_in = {bin_in[CARD_W-2:0], 1'b0};
      end
   end

   // one Luhn digit per cycle, checksum kept modulo ten
   assign cur_digit = bcd_ff[3:0];
   assign doubled   = {cur_digit, 1'b0};

   always_comb begin
      if (!count_ff[0]) begin
         addend = cur_digit;
      end else if (doubled >= 5'd10) begin
         addend = digit_type'(doubled - 5'd9);
      end else begin
         addend = doubled[3:0];
      end
   end

   assign sum_raw = {1'b0, sum_ff} + {1'b0, addend};
   assign sum_in  = (sum_raw >= 5'd10) ? digit_type'(sum_raw - 5'd10) : sum_raw[3:0];

   assign overflow = (bcd_ff != '0);
   assign ok_in    = !overflow && (sum_ff == '0);

   always_comb begin
      brand_in = BRAND_INVALID;
      if (ok_in && (count_ff inside {[VISA_LEN_MIN:VISA_LEN_MAX]})) begin
         if (lead_ff == VISA_LEAD) begin
            brand_in = BRAND_VISA;
         end else if ((count_ff == MC_LEN) && (lead_ff == MC_LEAD) &&
                      (second_ff inside {[MC_SECOND_LO:MC_SECOND_HI]})) begin
            brand_in = BRAND_MASTERCARD;
         end else if ((count_ff == AMEX_LEN) && (lead_ff == AMEX_LEAD) &&
                      (second_ff inside {AMEX_SECOND_A, AMEX_SECOND_B})) begin
            brand_in = BRAND_AMEX;
         end
      end
   end

   assign status.conv_more  = (conv_cnt_ff != CONV_CNT_W'(CONV_STEPS - 1));
   assign status.digit_more = (bcd_ff != '0) && (count_ff != COUNT_W'(MAX_DIGITS));
   assign status.out_busy   = rsp_valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         case (ctrl.op)
            OP_LOAD: begin
               bin_ff      <= card_number;
               bcd_ff      <= '0;
               conv_cnt_ff <= '0;
               count_ff    <= '0;
               sum_ff      <= '0;
               lead_ff     <= '0;
               second_ff   <= '0;
            end
            OP_CONVERT: begin
               bin_ff      <= bin_in;
               bcd_ff      <= bcd_in;
               conv_cnt_ff <= conv_cnt_ff + 1'b1;
            end
            OP_DIGIT: begin
               bcd_ff    <= {4'd0, bcd_ff[BCD_W-1:4]};
               sum_ff    <= sum_in;
               second_ff <= lead_ff;
               lead_ff   <= cur_digit;
               count_ff  <= count_ff + 1'b1;
            end
            OP_CLASSIFY: begin
               brand_ff  <= brand_in;
               ok_ff     <= ok_in;
               dcount_ff <= count_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.en && (ctrl.op == OP_CLASSIFY)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign brand       = brand_ff;
   assign luhn_ok     = ok_ff;
   assign digit_count = dcount_ff;

endmodule

// File: dv/luhn_card_brand_check_test.sv
`timescale 1ns / 100ps

module luhn_card_brand_check_test;
   import lcbc_pkg::*;

   localparam int MAX_DIGITS = 19;
   localparam int ITEM_COUNT = 1450;
   localparam longint unsigned CARD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   class card_verdict_board;
      typedef struct {
         brand_type  brand;
         logic       luhn_ok;
         logic [4:0] digit_count;
      } verdict_type;

      verdict_type verdicts_due[$];
      int          errors = 0;

      // Digit walk from the least significant digit, doubling every second one.
      function verdict_type card_verdict(logic [62:0] card);
         longint unsigned rest;
         int unsigned sum, n, lead, second, d, twice, two;
         verdict_type v;
         rest = {1'b0, card};
         sum = 0;
         n = 0;
         lead = 0;
         second = 0;
         while (rest != 0 && n < MAX_DIGITS) begin
            d = 32'(rest % 10);
            if (n % 2 == 0) begin
               sum += d;
            end else begin
               twice = 2 * d;
               sum += (twice >= 10) ? twice - 9 : twice;
            end
            second = lead;
            lead = d;
            n++;
            rest = rest / 10;
         end
         v.brand = BRAND_INVALID;
         if (rest != 0) begin
            v.luhn_ok = 1'b0;
            v.digit_count = 5'(MAX_DIGITS);
            return v;
         end
         v.luhn_ok = (sum % 10 == 0);
         v.digit_count = 5'(n);
         two = lead * 10 + second;
         if (v.luhn_ok && n >= 13 && n <= 16) begin
            if (lead == 4)
               v.brand = BRAND_VISA;
            else if (n == 16 && two >= 51 && two <= 55)
               v.brand = BRAND_MASTERCARD;
            else if (n == 15 && (two == 34 || two == 37))
               v.brand = BRAND_AMEX;
         end
         return v;
      endfunction

      function void note_card(logic [62:0] card);
         verdicts_due.push_back(card_verdict(card));
      endfunction

      function void check_word(logic [RSP_DATA_W-1:0] word);
         verdict_type want;
         if (verdicts_due.size() == 0) begin
            $display("%0t: result word %h with nothing expected", $time, word);
            errors++;
            return;
         end
         want = verdicts_due.pop_front();
         if (word[1:0] !== want.brand) begin
            $display("%0t: brand expected %0d actual %0d", $time, want.brand, word[1:0]);
            errors++;
         end
         if (word[2] !== want.luhn_ok) begin
            $display("%0t: luhn_ok expected %0d actual %0d", $time, want.luhn_ok, word[2]);
            errors++;
         end
         if (word[7:3] !== want.digit_count) begin
            $display("%0t: digit_count expected %0d actual %0d", $time,
                     want.digit_count, word[7:3]);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [62:0] card_number, [63] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [1:0] brand, [2] luhn_ok, [7:3] digit_count

   card_verdict_board book = new();
   bit steady = 1'b0;
   int stall_left = 0;
   int stall_pick;

   luhn_card_brand_check #(.MAX_DIGITS(MAX_DIGITS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: mostly ready, short stalls, now and then a long one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 70) begin
            rsp_tready <= 1'b1;
         end else if (stall_pick < 95) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(10, 30);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         book.check_word(rsp_tdata);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 70)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // Replace the last digit so that the checksum passes or fails as asked.
   function automatic longint unsigned fix_check(longint unsigned value, bit pass);
      longint unsigned base;
      longint unsigned cand;
      card_verdict_board::verdict_type got;
      int r;
      if (value > CARD_MAX - 20)
         value -= 20;
      base = value - value % 10;
      r = $urandom_range(0, 9);
      for (int k = 0; k < 10; k++) begin
         cand = base + 64'((r + k) % 10);
         got = book.card_verdict(cand[62:0]);
         if (got.luhn_ok == pass)
            return cand;
      end
      return base;
   endfunction

   // Number of len digits (len up to 18) that starts with the given head.
   function automatic longint unsigned make_card(int len, longint unsigned head,
                                                 int head_len, bit pass);
      longint unsigned value;
      value = head;
      for (int i = head_len; i < len; i++)
         value = value * 10 + $urandom_range(0, 9);
      return fix_check(value, pass);
   endfunction

   function automatic longint unsigned raw_card();
      return {$urandom, $urandom} >> 1;
   endfunction

   task automatic send_card(longint unsigned card);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, card[62:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_card(card[62:0]);
   endtask

   function automatic longint unsigned random_card();
      int r;
      int len;
      r = $urandom_range(0, 99);
      if (r < 20)
         return make_card($urandom_range(13, 16), 4, 1, 1'b1);
      if (r < 35)
         return make_card(16, $urandom_range(51, 55), 2, 1'b1);
      if (r < 50)
         return make_card(15, $urandom_range(0, 1) ? 34 : 37, 2, 1'b1);
      if (r < 65)
         return make_card($urandom_range(12, 17), $urandom_range(10, 99), 2,
                          1'($urandom_range(0, 1)));
      if (r < 80) begin
         len = $urandom_range(1, 18);
         return make_card(len, $urandom_range(1, 9), 1, 1'($urandom_range(0, 1)));
      end
      if (r < 90)
         return raw_card();
      return fix_check(raw_card() | 64'd1_000_000_000_000_000_000,
                       1'($urandom_range(0, 1)));
   endfunction

   initial begin
      longint unsigned directed[$];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = '{
         64'd0, CARD_MAX, 64'd1, 64'd9,
         make_card(13, 4, 1, 1'b1), make_card(14, 4, 1, 1'b1),
         make_card(15, 4, 1, 1'b1), make_card(16, 4, 1, 1'b1),
         make_card(16, 4, 1, 1'b0), make_card(13, 4, 1, 1'b0),
         make_card(12, 4, 1, 1'b1), make_card(17, 4, 1, 1'b1),
         make_card(16, 51, 2, 1'b1), make_card(16, 55, 2, 1'b1),
         make_card(16, 50, 2, 1'b1), make_card(16, 56, 2, 1'b1),
         make_card(15, 53, 2, 1'b1),
         make_card(15, 34, 2, 1'b1), make_card(15, 37, 2, 1'b1),
         make_card(15, 35, 2, 1'b1), make_card(16, 34, 2, 1'b1),
         make_card(15, 37, 2, 1'b0),
         fix_check(64'd9_000_000_000_000_000_000, 1'b1),
         make_card(18, 9, 1, 1'b1)
      };
      foreach (directed[i])
         send_card(directed[i]);

      for (int i = 0; i < ITEM_COUNT - directed.size(); i++) begin
         // every third block of 150 runs with both sides at full rate
         steady = ((i / 150) % 3 == 1);
         send_card(random_card());
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      while (book.verdicts_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (book.errors == 0)
         $display("luhn_card_brand_check_test passed");
      else
         $display("luhn_card_brand_check_test failed");
      $finish;
   end

   initial begin
      #2_500_000;
      $display("luhn_card_brand_check_test failed");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/lcbc_pkg.sv
hw/rtl/lcbc_seq.sv
hw/rtl/lcbc_dpath.sv
hw/rtl/luhn_card_brand_check.sv
dv/luhn_card_brand_check_test.sv
